// ===== design/gpm_pkg.sv =====
// Package with shared types and codes for the pushbuffer method parser.
`timescale 1ns / 1ps
package gpm_pkg;

  localparam logic [1:0] KIND_METHOD  = 2'd0;
  localparam logic [1:0] KIND_INLINE  = 2'd1;
  localparam logic [1:0] KIND_BADMODE = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  localparam logic [3:0] MODE_INCR    = 4'd1;
  localparam logic [3:0] MODE_NONINCR = 4'd2;
  localparam logic [3:0] MODE_INLINE  = 4'd3;
  localparam logic [3:0] MODE_IGNORE  = 4'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] method_addr;
    logic [2:0]  subchannel;
    logic [31:0] data;
  } result_t;

  typedef struct packed {
    result_t first;
    logic    two;
    result_t second;
  } record_t;

  typedef struct packed {
    logic owed_zero;
  } front_status_t;

  typedef struct packed {
    logic pending;
  } back_status_t;

endpackage

// ===== design/gpu_pushbuffer_method_parser_core.sv =====
// Top level of the pushbuffer method parser.
`timescale 1ns / 1ps
// The parser takes one command word per cycle while in_full is low and turns it into zero,
// one or two requests on the result side. Words that produce at most one request sustain
// one word per cycle while out_pop drains the output stage; a word that produces two
// requests (a write plus a truncation error on the final word) holds the single-request
// output stage for both requests in turn. The decoder and the output stage are separated
// by a record queue of QUEUE_DEPTH entries, so in_full only rises once that queue has
// filled; a result passes through the record queue and then the output register.
module gpu_pushbuffer_method_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_word,
  input  logic        in_final_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [13:0] out_method_addr,
  output logic [2:0]  out_subchannel,
  output logic [31:0] out_data,
  output logic        out_last_of_run
);
  import gpm_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic              rec_push;
  record_t           rec;
  front_status_t     fr_status;
  logic              q_pop, q_valid;
  record_t           q_head;
  logic [CNT_W-1:0]  q_count;
  result_t           res;
  back_status_t      bk_status;

  assign accept = in_push && !in_full;

  gpm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .word       (in_word),
    .final_word (in_final_word),
    .rec_push   (rec_push),
    .rec        (rec),
    .status     (fr_status)
  );

  gpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (q_pop),
    .full     (in_full),
    .valid    (q_valid),
    .head     (q_head),
    .count    (q_count)
  );

  gpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res),
    .out_last  (out_last_of_run),
    .status    (bk_status)
  );

  assign out_kind        = res.kind;
  assign out_method_addr = res.method_addr;
  assign out_subchannel  = res.subchannel;
  assign out_data        = res.data;

  a_pending_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.pending |-> !out_empty)
    else $error("second request pending without an occupied output stage");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("record queue count above its depth");

  a_final_clears_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_final_word) |=> fr_status.owed_zero)
    else $error("argument words still owed after the final word");

  a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_status.pending && out_pop && !out_empty) |=> (out_last_of_run && !out_empty))
    else $error("second request of a word not marked as last");

endmodule

// ===== design/gpm_front.sv =====
// Front end: decodes command words, tracks owed arguments and builds result records.
`timescale 1ns / 1ps
module gpm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [31:0]            word,
  input  logic                   final_word,
  output logic                   rec_push,
  output gpm_pkg::record_t       rec,
  output gpm_pkg::front_status_t status
);
  import gpm_pkg::*;

  logic [11:0] owed_r, owed_nxt;
  logic [13:0] method_r, method_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic        incr_r, incr_nxt;

  logic        r0_valid;
  result_t     r0;
  logic        trunc;
  result_t     tr;
  logic [3:0]  mode;

  always_comb begin
    owed_nxt   = owed_r;
    method_nxt = method_r;
    sub_nxt    = sub_r;
    incr_nxt   = incr_r;
    r0_valid   = 1'b0;
    r0         = '0;
    mode       = word[31:28];
    if (owed_r != 12'd0) begin
      r0_valid = 1'b1;
      r0 = '{kind: KIND_METHOD, method_addr: method_r, subchannel: sub_r, data: word};
      if (incr_r) begin
        method_nxt = method_r + 14'd1;
      end
      owed_nxt = owed_r - 12'd1;
    end else begin
      case (mode)
        MODE_INCR, MODE_NONINCR: begin
          owed_nxt   = word[27:16];
          method_nxt = {1'b0, word[12:0]};
          sub_nxt    = word[15:13];
          incr_nxt   = (mode == MODE_INCR);
        end
        MODE_INLINE: begin
          r0_valid = 1'b1;
          r0 = '{kind: KIND_INLINE, method_addr: {1'b0, word[12:0]},
                 subchannel: word[15:13], data: {20'd0, word[27:16]}};
        end
        MODE_IGNORE: begin
          r0_valid = 1'b0;
        end
        default: begin
          r0_valid = 1'b1;
          r0 = '{kind: KIND_BADMODE, method_addr: 14'd0, subchannel: 3'd0,
                 data: {28'd0, mode}};
        end
      endcase
    end
    trunc = final_word && (owed_nxt != 12'd0);
    tr = '{kind: KIND_TRUNC, method_addr: method_nxt, subchannel: sub_nxt,
           data: {20'd0, owed_nxt}};
    if (final_word) begin
      owed_nxt = 12'd0;
    end
  end

  assign rec_push         = accept && (r0_valid || trunc);
  assign rec.first        = r0_valid ? r0 : tr;
  assign rec.two          = r0_valid && trunc;
  assign rec.second       = tr;
  assign status.owed_zero = (owed_r == 12'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r   <= '0;
      method_r <= '0;
      sub_r    <= '0;
      incr_r   <= 1'b0;
    end else if (accept) begin
      owed_r   <= owed_nxt;
      method_r <= method_nxt;
      sub_r    <= sub_nxt;
      incr_r   <= incr_nxt;
    end
  end

endmodule

// ===== design/gpm_queue.sv =====
// Small record queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module gpm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  gpm_pkg::record_t                push_rec,
  input  logic                            pop,
  output logic                            full,
  output logic                            valid,
  output gpm_pkg::record_t                head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);
  import gpm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  record_t           slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_r];
  assign count   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/gpm_back.sv =====
// Back end: splits records into single results and holds the output register.
`timescale 1ns / 1ps
module gpm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  gpm_pkg::record_t      q_head,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output gpm_pkg::result_t      out_res,
  output logic                  out_last,
  output gpm_pkg::back_status_t status
);
  import gpm_pkg::*;

  logic    out_valid_r;
  result_t out_r;
  logic    last_r;
  logic    sec_valid_r;
  result_t sec_r;
  logic    load;

  assign load           = !out_valid_r || out_pop;
  assign q_pop          = load && !sec_valid_r && q_valid;
  assign out_empty      = !out_valid_r;
  assign out_res        = out_r;
  assign out_last       = last_r;
  assign status.pending = sec_valid_r;

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        out_r  <= sec_r;
        last_r <= 1'b1;
      end else begin
        out_r  <= q_head.first;
        last_r <= !q_head.two;
      end
    end
    if (q_pop) begin
      sec_r <= q_head.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= q_valid;
        sec_valid_r <= q_valid && q_head.two;
      end
    end
  end

endmodule
